/* hdl/homography_point_transform_unit_macros.svh */
// Assertion macros for the homography point transform unit.
`ifndef HOMOGRAPHY_POINT_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGRAPHY_POINT_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hpt_pkg.sv */
// Types and constants of the homography point transform unit.
`default_nettype none

package hpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QBITS     = 31;
    localparam int SUM_W     = 66;
    localparam int MAG_W     = 65;
    localparam int REM_W     = MAG_W + QBITS + 1;
    localparam int PIPE_LAT  = QBITS + 5;

    localparam logic [31:0] ONE_Q   = 32'(1 << FRAC_BITS);
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [2:0] {
        CFG_PAIR_A = 3'd0,
        CFG_PAIR_B = 3'd1,
        CFG_PAIR_C = 3'd2,
        CFG_PAIR_D = 3'd3,
        CFG_LAST   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic               point_ok;
    } point_t;

    typedef struct packed {
        logic signed [31:0] dst_x;
        logic signed [31:0] dst_y;
        logic               dst_ok;
        logic               behind_flag;
        logic               zero_w_flag;
    } result_t;

    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [QBITS-1:0] q_x;
        logic [QBITS-1:0] q_y;
        logic [MAG_W-1:0] den;
        logic             ov_x;
        logic             ov_y;
        logic             nneg_x;
        logic             nneg_y;
        logic             nzero_x;
        logic             nzero_y;
        logic             wneg;
        logic             wzero;
        logic             ok;
        logic [31:0]      src_x;
        logic [31:0]      src_y;
    } div_stage_t;

endpackage

`default_nettype wire

/* hdl/homography_point_transform_unit.sv */
// Top level of the homography point transform unit: a pipelined projective map.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+------------------------------
//  input    | start, busy, point                     | item taken when start && !busy
//  result   | done, result                           | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_addr, cfg_wdata            | write when cfg_we is high
//
// One item enters per cycle while busy is low; each result leaves through the
// stages multiply, sum, magnitude, overflow test, 31 restoring divide steps and
// format. Both quotients share the denominator and run side by side.
// busy is high only during reset and the cycle that follows it.
// The result side cannot stall, so the pipeline advances every cycle.
`default_nettype none
`include "homography_point_transform_unit_macros.svh"

module homography_point_transform_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire hpt_pkg::point_t point,
    output logic                 done,
    output hpt_pkg::result_t     result,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_addr,
    input  wire logic [63:0]     cfg_wdata
);
    import hpt_pkg::*;

    logic [63:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [31:0] coef_l_reg;
    logic        busy_reg;

    // Write configuration registers; ignore unused indexes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            coef_a_reg <= {32'd0, ONE_Q};
            coef_b_reg <= 64'd0;
            coef_c_reg <= {32'd0, ONE_Q};
            coef_d_reg <= 64'd0;
            coef_l_reg <= ONE_Q;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PAIR_A: coef_a_reg <= cfg_wdata;
                CFG_PAIR_B: coef_b_reg <= cfg_wdata;
                CFG_PAIR_C: coef_c_reg <= cfg_wdata;
                CFG_PAIR_D: coef_d_reg <= cfg_wdata;
                CFG_LAST:   coef_l_reg <= cfg_wdata[31:0];
                default:    ;
            endcase
        end
    end

    // Hold off items until reset is done
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) busy_reg <= 1'b1;
        else        busy_reg <= 1'b0;
    end
    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // Stage 1: products
    logic signed [63:0] prod_reg [6];
    logic signed [31:0] offs_reg [3];
    logic        [31:0] s1_x_reg, s1_y_reg;
    logic               s1_ok_reg, s1_vld_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) s1_vld_reg <= 1'b0;
        else        s1_vld_reg <= accept;
    end

    always_ff @(posedge clk) begin
        prod_reg[0] <= $signed(coef_a_reg[31:0])  * point.src_x;
        prod_reg[1] <= $signed(coef_a_reg[63:32]) * point.src_y;
        prod_reg[2] <= $signed(coef_b_reg[63:32]) * point.src_x;
        prod_reg[3] <= $signed(coef_c_reg[31:0])  * point.src_y;
        prod_reg[4] <= $signed(coef_d_reg[31:0])  * point.src_x;
        prod_reg[5] <= $signed(coef_d_reg[63:32]) * point.src_y;
        offs_reg[0] <= $signed(coef_b_reg[31:0]);
        offs_reg[1] <= $signed(coef_c_reg[63:32]);
        offs_reg[2] <= $signed(coef_l_reg);
        s1_x_reg    <= point.src_x;
        s1_y_reg    <= point.src_y;
        s1_ok_reg   <= point.point_ok;
    end

    // Stage 2: exact sums at scale 2^(2*FRAC_BITS)
    logic signed [SUM_W-1:0] sum_reg [3];
    logic        [31:0]      s2_x_reg, s2_y_reg;
    logic                    s2_ok_reg, s2_vld_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) s2_vld_reg <= 1'b0;
        else        s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < 3; k++) begin
            sum_reg[k] <= SUM_W'(prod_reg[2*k]) + SUM_W'(prod_reg[2*k+1])
                        + (SUM_W'(offs_reg[k]) <<< FRAC_BITS);
        end
        s2_x_reg  <= s1_x_reg;
        s2_y_reg  <= s1_y_reg;
        s2_ok_reg <= s1_ok_reg;
    end

    // Stage 3: magnitudes and signs
    logic [MAG_W-1:0] mag_reg [3];
    logic [2:0]       neg_reg;
    logic [31:0]      s3_x_reg, s3_y_reg;
    logic             s3_ok_reg, s3_vld_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) s3_vld_reg <= 1'b0;
        else        s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < 3; k++) begin
            neg_reg[k] <= sum_reg[k][SUM_W-1];
            mag_reg[k] <= sum_reg[k][SUM_W-1] ? MAG_W'(-sum_reg[k]) : MAG_W'(sum_reg[k]);
        end
        s3_x_reg  <= s2_x_reg;
        s3_y_reg  <= s2_y_reg;
        s3_ok_reg <= s2_ok_reg;
    end

    // Stage 4: scale numerators, test quotient overflow
    div_stage_t       stg_reg [QBITS+1];
    logic [QBITS:0]   stg_vld_reg;
    div_stage_t       stg0_next;
    logic [REM_W-1:0] num_x, num_y, den_top;

    always_comb begin
        num_x   = REM_W'(mag_reg[0]) << FRAC_BITS;
        num_y   = REM_W'(mag_reg[1]) << FRAC_BITS;
        den_top = REM_W'(mag_reg[2]) << QBITS;
        stg0_next.rem_x   = num_x;
        stg0_next.rem_y   = num_y;
        stg0_next.q_x     = '0;
        stg0_next.q_y     = '0;
        stg0_next.den     = mag_reg[2];
        stg0_next.ov_x    = num_x >= den_top;
        stg0_next.ov_y    = num_y >= den_top;
        stg0_next.nneg_x  = neg_reg[0];
        stg0_next.nneg_y  = neg_reg[1];
        stg0_next.nzero_x = mag_reg[0] == '0;
        stg0_next.nzero_y = mag_reg[1] == '0;
        stg0_next.wneg    = neg_reg[2];
        stg0_next.wzero   = mag_reg[2] == '0;
        stg0_next.ok      = s3_ok_reg;
        stg0_next.src_x   = s3_x_reg;
        stg0_next.src_y   = s3_y_reg;
    end

    // Divide steps: one quotient bit per stage, most significant first
    div_stage_t       stg_next [QBITS+1];
    logic [REM_W-1:0] dd [QBITS];

    always_comb begin
        stg_next[0] = stg0_next;
        for (int j = 0; j < QBITS; j++) begin
            stg_next[j+1] = stg_reg[j];
            dd[j] = REM_W'(stg_reg[j].den) << (QBITS - 1 - j);
            if (stg_reg[j].rem_x >= dd[j]) begin
                stg_next[j+1].rem_x = stg_reg[j].rem_x - dd[j];
                stg_next[j+1].q_x[QBITS-1-j] = 1'b1;
            end
            if (stg_reg[j].rem_y >= dd[j]) begin
                stg_next[j+1].rem_y = stg_reg[j].rem_y - dd[j];
                stg_next[j+1].q_y[QBITS-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) stg_vld_reg <= '0;
        else        stg_vld_reg <= {stg_vld_reg[QBITS-1:0], s3_vld_reg};
    end

    always_ff @(posedge clk) begin
        for (int j = 0; j <= QBITS; j++) begin
            stg_reg[j] <= stg_next[j];
        end
    end

    // Format: sign, saturate, pass invalid points through
    function automatic logic [31:0] fmt_q(input logic ov, input logic neg,
                                          input logic [QBITS-1:0] q);
        logic [31:0] qv;
        qv = 32'(q);
        if (ov) return neg ? SAT_NEG : SAT_POS;
        return neg ? 32'(-qv) : qv;
    endfunction

    function automatic logic [31:0] sat_sign(input logic nzero, input logic neg);
        if (nzero) return 32'd0;
        return neg ? SAT_NEG : SAT_POS;
    endfunction

    result_t    result_next, result_reg;
    logic       done_reg;
    div_stage_t fin;

    always_comb begin
        fin = stg_reg[QBITS];
        result_next.dst_ok      = fin.ok;
        result_next.behind_flag = fin.ok && !fin.wzero && fin.wneg;
        result_next.zero_w_flag = fin.ok && fin.wzero;
        priority if (!fin.ok) begin
            result_next.dst_x = fin.src_x;
            result_next.dst_y = fin.src_y;
        end else if (fin.wzero) begin
            result_next.dst_x = sat_sign(fin.nzero_x, fin.nneg_x);
            result_next.dst_y = sat_sign(fin.nzero_y, fin.nneg_y);
        end else begin
            result_next.dst_x = fmt_q(fin.ov_x, fin.nneg_x ^ fin.wneg, fin.q_x);
            result_next.dst_y = fmt_q(fin.ov_y, fin.nneg_y ^ fin.wneg, fin.q_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= stg_vld_reg[QBITS];
    end

    always_ff @(posedge clk) begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `HPT_ASSERT_IMP(a_latency, done, $past(start && !busy, PIPE_LAT), "result without item")
    `HPT_ASSERT_IMP(a_zero_w, done && result.zero_w_flag,
        result.dst_ok && !result.behind_flag, "zero w flag inconsistent")
    `HPT_ASSERT_IMP(a_zero_sat, done && result.zero_w_flag,
        (result.dst_x == SAT_POS || result.dst_x == SAT_NEG || result.dst_x == 32'd0),
        "zero w output not saturated")
    `HPT_ASSERT_NXT(a_busy_low, !busy, !busy, "busy rose outside reset")

endmodule

`default_nettype wire

/* tb/sv/homography_point_transform_unit_tb.sv */
// Self-checking testbench for the homography point transform unit.
`timescale 1ns / 1ps

module homography_point_transform_unit_tb;
    import hpt_pkg::*;

    localparam int LATENCY   = 36;
    localparam int RAND_ITEMS = 1000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int EXP_DEPTH = 256;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    point_t            point;
    logic              done;
    result_t           result;
    logic              cfg_we;
    logic [2:0]        cfg_addr;
    logic [63:0]       cfg_wdata;

    // Matrix copy h0..h8 kept alongside the block's registers
    logic signed [31:0] coef [0:8];

    // Expected results in order of acceptance, kept in a ring
    result_t           exp_mem [0:EXP_DEPTH-1];
    int                exp_wr;
    int                exp_rd;
    int                mismatch_cnt;
    int                result_cnt;
    int                cycle_cnt;
    int                zero_w_cnt;
    int                behind_cnt;

    homography_point_transform_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .point    (point),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Exact quotient num/den, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] div_sat(logic signed [127:0] num,
                                            logic signed [127:0] den);
        logic signed [127:0] quo;
        quo = (num <<< FRAC_BITS) / den;
        if (quo > 128'sh7FFF_FFFF)
            return SAT_POS;
        if (quo < -128'sh8000_0000)
            return SAT_NEG;
        return quo[31:0];
    endfunction

    function automatic logic [31:0] sign_sat(logic signed [127:0] num);
        if (num == 0)
            return 32'd0;
        return (num < 0) ? SAT_NEG : SAT_POS;
    endfunction

    // Map one point through the current matrix
    function automatic result_t project_point(point_t p);
        result_t r;
        logic signed [127:0] px, py, nx, ny, w;
        r = '0;
        if (!p.point_ok)
        begin
            r.dst_x = p.src_x;
            r.dst_y = p.src_y;
            return r;
        end
        px = p.src_x;
        py = p.src_y;
        nx = coef[0] * px + coef[1] * py + (128'(coef[2]) <<< FRAC_BITS);
        ny = coef[3] * px + coef[4] * py + (128'(coef[5]) <<< FRAC_BITS);
        w  = coef[6] * px + coef[7] * py + (128'(coef[8]) <<< FRAC_BITS);
        r.dst_ok = 1'b1;
        if (w == 0)
        begin
            r.dst_x = sign_sat(nx);
            r.dst_y = sign_sat(ny);
            r.zero_w_flag = 1'b1;
        end
        else
        begin
            r.dst_x = div_sat(nx, w);
            r.dst_y = div_sat(ny, w);
            r.behind_flag = (w < 0);
        end
        return r;
    endfunction

    // Write one register and mirror it
    task automatic write_coef(cfg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PAIR_A: begin coef[0] = val[31:0]; coef[1] = val[63:32]; end
            CFG_PAIR_B: begin coef[2] = val[31:0]; coef[3] = val[63:32]; end
            CFG_PAIR_C: begin coef[4] = val[31:0]; coef[5] = val[63:32]; end
            CFG_PAIR_D: begin coef[6] = val[31:0]; coef[7] = val[63:32]; end
            CFG_LAST:   coef[8] = val[31:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                               logic [63:0] d, logic [31:0] e);
        write_coef(CFG_PAIR_A, a);
        write_coef(CFG_PAIR_B, b);
        write_coef(CFG_PAIR_C, c);
        write_coef(CFG_PAIR_D, d);
        write_coef(CFG_LAST, {32'd0, e});
    endtask

    // Append one expectation to the ring
    task automatic add_expect(result_t r);
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // Send one item with a given expectation, then hold start low for a gap
    task automatic send_item(point_t p, result_t r, int gap);
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy);
        add_expect(r);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send one item checked against the predictor
    task automatic send_point(point_t p, int gap);
        send_item(p, project_point(p), gap);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 65535)) - 32768);
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            3: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.src_x    = rand_coord();
        p.src_y    = rand_coord();
        p.point_ok = ($urandom_range(0, 9) != 0);
        return p;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (done)
            begin
                result_cnt <= result_cnt + 1;
                if (exp_wr == exp_rd)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd <= exp_rd + 1;
                    if (want.zero_w_flag) zero_w_cnt <= zero_w_cnt + 1;
                    if (want.behind_flag) behind_cnt <= behind_cnt + 1;
                    if (result.dst_x !== want.dst_x || result.dst_y !== want.dst_y ||
                        result.dst_ok !== want.dst_ok ||
                        result.behind_flag !== want.behind_flag ||
                        result.zero_w_flag !== want.zero_w_flag)
                    begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("mismatch: want %h %h %b%b%b got %h %h %b%b%b",
                                want.dst_x, want.dst_y, want.dst_ok,
                                want.behind_flag, want.zero_w_flag,
                                result.dst_x, result.dst_y, result.dst_ok,
                                result.behind_flag, result.zero_w_flag);
                    end
                end
            end
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Directed rows: point plus expected result where it is obvious
    typedef struct {
        point_t  p;
        bit      known;
        result_t r;
    } row_t;

    row_t rows [6];

    function automatic row_t mk(logic [31:0] x, logic [31:0] y, logic ok,
                                bit known, result_t r);
        row_t w;
        w.p = '{x, y, ok};
        w.known = known;
        w.r = r;
        return w;
    endfunction

    initial
    begin
        logic [63:0] v;
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        exp_wr = 0;
        exp_rd = 0;
        mismatch_cnt = 0;
        result_cnt = 0;
        cycle_cnt = 0;
        zero_w_cnt = 0;
        behind_cnt = 0;
        coef[0] = ONE_Q; coef[1] = 0; coef[2] = 0; coef[3] = 0;
        coef[4] = ONE_Q; coef[5] = 0; coef[6] = 0; coef[7] = 0; coef[8] = ONE_Q;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Identity after reset: extremes pass through, invalid passes through
        rows[0] = mk(SAT_POS, SAT_NEG, 1, 1, '{SAT_POS, SAT_NEG, 1, 0, 0});
        rows[1] = mk(SAT_NEG, SAT_POS, 1, 1, '{SAT_NEG, SAT_POS, 1, 0, 0});
        rows[2] = mk(0, 0, 1, 1, '{0, 0, 1, 0, 0});
        rows[3] = mk(32'hFFFF_FFFF, 32'h1, 1, 1, '{32'hFFFF_FFFF, 32'h1, 1, 0, 0});
        rows[4] = mk(32'h1234_5678, 32'hDEAD_BEEF, 0, 1,
                     '{32'h1234_5678, 32'hDEAD_BEEF, 0, 0, 0});
        rows[5] = mk(32'h0003_8000, 32'hFFFE_0000, 1, 1,
                     '{32'h0003_8000, 32'hFFFE_0000, 1, 0, 0});
        foreach (rows[i])
        begin
            if (rows[i].known)
                send_item(rows[i].p, rows[i].r, i % 3);
            else
                send_point(rows[i].p, i % 3);
        end
        drain();

        // Zero w, positive w and negative w cases
        load_matrix({32'h0, 32'h0002_0000}, {32'hFFFF_0000, 32'h0},
                    {32'h0, 32'h0},
                    {32'h0, 32'h0001_0000}, 32'h0);
        send_point('{0, 0, 1}, 0);                         // w zero, numerators zero
        send_point('{0, 32'h0001_0000, 1}, 0);             // w zero, numerators zero
        send_point('{32'h0001_0000, 0, 1}, 1);             // positive w
        send_point('{32'hFFFF_0000, 0, 1}, 0);             // behind
        send_point('{32'h0000_0001, 0, 1}, 2);             // tiny w
        send_point('{32'h0003_0000, 32'h0007_0000, 1}, 0); // larger w
        send_point('{SAT_NEG, SAT_NEG, 1}, 0);
        send_point('{SAT_POS, SAT_POS, 0}, 0);
        drain();

        // Extreme coefficients
        load_matrix({SAT_NEG, SAT_POS}, {SAT_POS, SAT_NEG}, {SAT_NEG, SAT_POS},
                    {SAT_POS, SAT_NEG}, SAT_NEG);
        for (int i = 0; i < 8; i++)
            send_point(rand_point(), $urandom_range(0, 2));
        drain();

        // Random phases, each with a fresh matrix
        n = 0;
        while (n < RAND_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: load_matrix({$urandom(), $urandom()}, {$urandom(), $urandom()},
                               {$urandom(), $urandom()}, {$urandom(), $urandom()},
                               $urandom());
                1: load_matrix({rand_coord(), rand_coord()}, {rand_coord(), rand_coord()},
                               {rand_coord(), rand_coord()},
                               {32'($signed($urandom_range(0, 511)) - 256),
                                32'($signed($urandom_range(0, 511)) - 256)},
                               rand_coord());
                default: load_matrix({rand_coord(), rand_coord()},
                                     {rand_coord(), rand_coord()},
                                     {rand_coord(), rand_coord()},
                                     {rand_coord(), rand_coord()}, rand_coord());
            endcase
            v = $urandom_range(50, 150);
            for (int i = 0; i < v; i++)
            begin
                send_point(rand_point(),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0);
                n++;
            end
            drain();
        end

        $display("checked %0d results over %0d random items; %0d zero-w, %0d behind",
                 result_cnt, n, zero_w_cnt, behind_cnt);
        if (mismatch_cnt == 0 && exp_wr == exp_rd)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
